// ===== rtl/tcpm_pkg.sv =====
// Shared types, constants and codes of the token class pattern matcher.
`timescale 1ns / 1ps

package tcpm_pkg;

    // Fixed field widths of the request and result items.
    localparam int CLASS_BITS    = 6;
    localparam int COLUMN_BITS   = 16;
    localparam int LINE_BITS     = 20;
    localparam int ACTION_BITS   = 3;

    // Pattern register layout.
    localparam int PAT_SLOTS     = 8;
    localparam int CODE_BITS     = 3;
    localparam int LEN_BITS      = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = PAT_SLOTS * CODE_BITS;

    // Default number of usable slots.
    localparam int MAX_SLOTS_DEF = 8;

    // Token class bits with a special meaning.
    localparam int CLS_ARTICLE   = 0;
    localparam int CLS_PUNCT     = 5;

    // Reset values of the pattern registers.
    localparam logic [LEN_BITS-1:0]      RST_LENGTH    = LEN_BITS'(1);
    localparam logic [CFG_DATA_BITS-1:0] RST_CLASSES   = '0;
    localparam logic [PAT_SLOTS-1:0]     RST_MANDATORY = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LENGTH    = 2'd0,
        CFG_CLASSES   = 2'd1,
        CFG_MANDATORY = 2'd2
    } t_cfg_idx;

    // Per-token action codes.
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ARTICLE = 3'd0,
        ACT_NOMATCH = 3'd1,
        ACT_ABANDON = 3'd2,
        ACT_PASS    = 3'd3,
        ACT_TAKE    = 3'd4
    } t_action;

    // Matcher modes.
    typedef enum logic [1:0] {
        M_RESET  = 2'd0,
        M_SEARCH = 2'd1,
        M_MATCH  = 2'd2
    } t_mode;

    // Outcome of matching one token against the current slot.
    typedef enum logic [1:0] {
        MT_FAIL = 2'd0,
        MT_PASS = 2'd1,
        MT_TAKE = 2'd2
    } t_match;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Input request payload.
    typedef struct packed {
        logic [CLASS_BITS-1:0]  token_classes;
        logic [COLUMN_BITS-1:0] token_column;
        logic [LINE_BITS-1:0]   line_number;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        t_action                token_action;
        logic                   phrase_started;
        logic                   phrase_found;
        logic [COLUMN_BITS-1:0] start_column;
        logic [LINE_BITS-1:0]   found_line;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic commit;
    } t_ctl_cmd;

endpackage

// ===== rtl/tcpm_ctrl.sv =====
// Controller state machine of the token class pattern matcher.
`timescale 1ns / 1ps

module tcpm_ctrl import tcpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_ctl_cmd o_cmd
);

    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    logic     n_out_valid;
    t_ctl_cmd w_cmd;
    logic     w_in_ready;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Take a request in idle, then commit it once the result register is free.
    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        w_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== rtl/tcpm_datapath.sv =====
// Datapath of the token class pattern matcher: pattern registers, slot match and result.
`timescale 1ns / 1ps

module tcpm_datapath import tcpm_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl_cmd                 i_cmd,
    input  t_in_item                 i_in_data,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_out_item                o_out_data
);

    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_N = 2 ** SLOT_W;
    localparam int CMP_W  = (SLOT_W > LEN_BITS) ? SLOT_W : LEN_BITS;
    localparam int TOK_N  = 2 ** CODE_BITS;

    // Pattern registers.
    logic [LEN_BITS-1:0]      r_len;
    logic [CFG_DATA_BITS-1:0] r_classes;
    logic [PAT_SLOTS-1:0]     r_mand;

    // Latched request and matcher state.
    t_in_item                 r_in;
    t_mode                    r_mode;
    t_mode                    n_mode;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        n_slot;
    logic [COLUMN_BITS-1:0]   r_psc;
    logic [COLUMN_BITS-1:0]   n_psc;
    t_out_item                r_out;
    t_out_item                n_out;

    // Combinational helpers.
    logic [CMP_W-1:0]         w_len_ext;
    logic [SLOT_W-1:0]        w_len;
    logic [TOK_N-1:0]         w_tok_ext;
    logic [CODE_BITS-1:0]     w_code [SLOT_N];
    logic [SLOT_N-1:0]        w_mand;
    logic [SLOT_N-1:0]        w_fit;
    t_mode                    w_mode_in;
    logic [SLOT_W-1:0]        w_slot_in;
    logic                     w_have_next;
    logic [SLOT_W-1:0]        w_next;
    t_match                   w_match;
    logic [SLOT_W-1:0]        w_slot_m;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= RST_LENGTH;
            r_classes <= RST_CLASSES;
            r_mand    <= RST_MANDATORY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LENGTH:    r_len     <= i_cfg_data[LEN_BITS-1:0];
                CFG_CLASSES:   r_classes <= i_cfg_data;
                CFG_MANDATORY: r_mand    <= i_cfg_data[PAT_SLOTS-1:0];
                default: ;
            endcase
        end
    end

    // Request latch and result register carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // Matcher state, updated when a request is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_RESET;
            r_slot <= '0;
            r_psc  <= '0;
        end else if (i_cmd.commit) begin
            r_mode <= n_mode;
            r_slot <= n_slot;
            r_psc  <= n_psc;
        end
    end

    // Effective pattern length: zero acts as one, clamp to the slot count.
    always_comb begin
        w_len_ext = CMP_W'(r_len);
        if (w_len_ext == '0) begin
            w_len = SLOT_W'(1);
        end else if (w_len_ext > CMP_W'(MAX_SLOTS)) begin
            w_len = SLOT_W'(MAX_SLOTS);
        end else begin
            w_len = SLOT_W'(w_len_ext);
        end
    end

    // Per-slot class code, mandatory flag and fit; slots past the registers are
    // article-class and optional. Codes six and seven select zero bits.
    assign w_tok_ext = TOK_N'(r_in.token_classes);

    for (genvar g = 0; g < SLOT_N; g++) begin : g_slot
        if (g < PAT_SLOTS) begin : g_reg
            assign w_code[g] = r_classes[g*CODE_BITS +: CODE_BITS];
            assign w_mand[g] = r_mand[g];
        end else begin : g_pad
            assign w_code[g] = '0;
            assign w_mand[g] = 1'b0;
        end
        assign w_fit[g] = w_tok_ext[w_code[g]];
    end

    // A token outside a phrase restarts the search at slot zero.
    always_comb begin
        if (r_mode == M_SEARCH || r_mode == M_MATCH) begin
            w_mode_in = r_mode;
            w_slot_in = r_slot;
        end else begin
            w_mode_in = M_SEARCH;
            w_slot_in = '0;
        end
    end

    // Priority scan for the first mandatory slot after the current one.
    always_comb begin
        w_have_next = 1'b0;
        w_next      = '0;
        for (int s = SLOT_N - 1; s >= 0; s--) begin
            if (SLOT_W'(s) > w_slot_in && SLOT_W'(s) < w_len && w_mand[s]) begin
                w_have_next = 1'b1;
                w_next      = SLOT_W'(s);
            end
        end
    end

    // Match the token against the current slot, or jump to the next mandatory one.
    always_comb begin
        w_match  = MT_PASS;
        w_slot_m = w_slot_in;
        if (r_in.token_classes[CLS_PUNCT]) begin
            w_match = MT_FAIL;
        end else if (w_slot_in >= w_len) begin
            w_match = MT_PASS;
        end else if (w_fit[w_slot_in]) begin
            w_match  = MT_TAKE;
            w_slot_m = w_slot_in + SLOT_W'(1);
        end else if (w_mand[w_slot_in]) begin
            w_match = MT_FAIL;
        end else if (w_have_next && w_fit[w_next]) begin
            w_match  = MT_TAKE;
            w_slot_m = w_next + SLOT_W'(1);
        end
    end

    // Next matcher state and the result item.
    always_comb begin
        n_mode = r_mode;
        n_slot = r_slot;
        n_psc  = r_psc;
        n_out  = '0;
        if (r_in.token_classes[CLS_ARTICLE]) begin
            // Articles leave the matcher untouched.
            n_out.token_action = ACT_ARTICLE;
            n_out.start_column = (r_mode == M_MATCH) ? r_psc : '0;
        end else begin
            n_slot = w_slot_m;
            n_mode = w_mode_in;
            if (w_mode_in == M_SEARCH) begin
                if (w_match == MT_FAIL) begin
                    n_out.token_action = ACT_NOMATCH;
                end else begin
                    n_out.token_action   = (w_match == MT_TAKE) ? ACT_TAKE : ACT_PASS;
                    n_out.phrase_started = 1'b1;
                    n_psc                = r_in.token_column;
                    n_mode               = M_MATCH;
                end
            end else begin
                if (w_match == MT_FAIL) begin
                    n_out.token_action = ACT_ABANDON;
                    n_mode             = M_RESET;
                end else begin
                    n_out.token_action = (w_match == MT_TAKE) ? ACT_TAKE : ACT_PASS;
                end
            end
            // Every slot consumed: report the find and return to reset mode.
            if (w_slot_m >= w_len) begin
                n_out.phrase_found = 1'b1;
                n_out.found_line   = r_in.line_number;
                n_mode             = M_RESET;
            end
            if (n_out.phrase_found || n_mode == M_MATCH) begin
                n_out.start_column = n_psc;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/token_class_pattern_matcher_unit.sv =====
// A request is latched when accepted, then matched against the slot pattern
// and committed with the matcher state once the result register is free; the
// result shows after that commit, and no new request is taken before it.
// The result register lets the next request in while a result waits downstream.
// Reset (i_rst_n low, synchronous) restores the pattern registers to their
// defaults and returns the matcher to its reset mode at slot zero.
`timescale 1ns / 1ps

module token_class_pattern_matcher_unit import tcpm_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_ctl_cmd w_cmd;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Sequencing of requests and results.
    tcpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Pattern registers, slot matching and result register.
    tcpm_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/tcpm_checker.sv =====
// Port-level assertions for the token class pattern matcher and their bind.
`timescale 1ns / 1ps

module tcpm_checker import tcpm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // One request at a time: after an accept the input side is closed in the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while the previous one is still in work");

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed or dropped before it was taken");

    // The found line is only reported with a find.
    a_line_with_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.phrase_found) |-> (o_out_data.found_line == '0))
        else $error("found line set without a find");

    // A skipped article neither starts nor completes a phrase.
    a_article_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_action == ACT_ARTICLE)
        |-> (!o_out_data.phrase_started && !o_out_data.phrase_found))
        else $error("article token changed the phrase state");

    // A phrase only starts on a token that was taken or passed over.
    a_start_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.phrase_started)
        |-> (o_out_data.token_action == ACT_TAKE || o_out_data.token_action == ACT_PASS))
        else $error("phrase started on a failing token");

endmodule

bind token_class_pattern_matcher_unit tcpm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== test/tb_top.sv =====
// Self-checking testbench of the token class pattern matcher unit.
`timescale 1ns / 1ps

module tb_top;
    import tcpm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_COUNT     = 16;
    localparam int WORDS_PER_PHASE = 106;
    localparam int PRINT_LIMIT     = 50;

    // Kinds of rows in the directed table.
    typedef enum logic {
        ROW_WORD    = 1'b0,
        ROW_PATTERN = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_in_item               req;
        logic                   typed;
        t_out_item              result;
        logic [LEN_BITS-1:0]    pat_len;
        logic [CFG_DATA_BITS-1:0] pat_classes;
        logic [PAT_SLOTS-1:0]   pat_mand;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Pattern registers and matcher state as the checker sees them.
    logic [LEN_BITS-1:0]      pat_len     = RST_LENGTH;
    logic [CFG_DATA_BITS-1:0] pat_classes = RST_CLASSES;
    logic [PAT_SLOTS-1:0]     pat_mand    = RST_MANDATORY;
    t_mode                    phrase_mode = M_RESET;
    logic [3:0]               phrase_slot = '0;
    logic [COLUMN_BITS-1:0]   phrase_col  = '0;

    t_out_item phrase_results_q[$];
    t_row      plan[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        rx_mode = 0;
    int        rx_left = 0;

    token_class_pattern_matcher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // A slot fits when its class code is a real class and the token has that bit.
    function automatic logic slot_fits(int s, logic [CLASS_BITS-1:0] cls);
        logic [CODE_BITS-1:0] code;
        code = (s >= PAT_SLOTS) ? '0 : pat_classes[CODE_BITS*s +: CODE_BITS];
        if (code > CODE_BITS'(CLS_PUNCT)) return 1'b0;
        return cls[code];
    endfunction

    function automatic logic slot_mandatory(int s);
        if (s >= PAT_SLOTS) return 1'b0;
        return pat_mand[s];
    endfunction

    // Matches one token at the current slot; a miss at an optional slot may
    // still land on the next mandatory slot.
    function automatic t_match match_slot(logic [CLASS_BITS-1:0] cls, logic [3:0] len);
        int s;
        if (cls[CLS_PUNCT]) return MT_FAIL;
        if (phrase_slot >= len) return MT_PASS;
        if (slot_fits(int'(phrase_slot), cls)) begin
            phrase_slot = phrase_slot + 4'd1;
            return MT_TAKE;
        end
        if (slot_mandatory(int'(phrase_slot))) return MT_FAIL;
        for (s = int'(phrase_slot) + 1; s < int'(len); s++) begin
            if (slot_mandatory(s)) begin
                if (!slot_fits(s, cls)) return MT_PASS;
                phrase_slot = 4'(s + 1);
                return MT_TAKE;
            end
        end
        return MT_PASS;
    endfunction

    // Works out the result of one request and advances the matcher state.
    function automatic t_out_item predict_phrase_step(t_in_item req);
        t_out_item res;
        logic [3:0] len;
        t_match r;
        res = '0;
        if (pat_len == '0) len = 4'd1;
        else if (pat_len > LEN_BITS'(MAX_SLOTS_DEF)) len = 4'(MAX_SLOTS_DEF);
        else len = pat_len;
        if (req.token_classes[CLS_ARTICLE]) begin
            res.token_action = ACT_ARTICLE;
        end else begin
            if (phrase_mode != M_SEARCH && phrase_mode != M_MATCH) begin
                phrase_slot = '0;
                phrase_mode = M_SEARCH;
            end
            r = match_slot(req.token_classes, len);
            if (phrase_mode == M_SEARCH) begin
                if (r == MT_FAIL) begin
                    res.token_action = ACT_NOMATCH;
                end else begin
                    res.token_action = (r == MT_TAKE) ? ACT_TAKE : ACT_PASS;
                    res.phrase_started = 1'b1;
                    phrase_col = req.token_column;
                    phrase_mode = M_MATCH;
                end
            end else if (r == MT_FAIL) begin
                res.token_action = ACT_ABANDON;
                phrase_mode = M_RESET;
            end else begin
                res.token_action = (r == MT_TAKE) ? ACT_TAKE : ACT_PASS;
            end
            if (phrase_slot >= len) begin
                res.phrase_found = 1'b1;
                phrase_mode = M_RESET;
            end
        end
        res.start_column = (res.phrase_found || phrase_mode == M_MATCH) ? phrase_col : '0;
        res.found_line = res.phrase_found ? req.line_number : '0;
        return res;
    endfunction

    function automatic t_out_item result_of(t_action act, logic started, logic found,
                                            logic [COLUMN_BITS-1:0] col,
                                            logic [LINE_BITS-1:0] line);
        t_out_item res;
        res.token_action   = act;
        res.phrase_started = started;
        res.phrase_found   = found;
        res.start_column   = col;
        res.found_line     = line;
        return res;
    endfunction

    function automatic t_row word_row(logic [CLASS_BITS-1:0] cls,
                                      logic [COLUMN_BITS-1:0] col,
                                      logic [LINE_BITS-1:0] line);
        t_row row;
        row = '0;
        row.kind = ROW_WORD;
        row.req.token_classes = cls;
        row.req.token_column = col;
        row.req.line_number = line;
        return row;
    endfunction

    function automatic t_row checked_row(logic [CLASS_BITS-1:0] cls,
                                         logic [COLUMN_BITS-1:0] col,
                                         logic [LINE_BITS-1:0] line, t_out_item res);
        t_row row;
        row = word_row(cls, col, line);
        row.typed = 1'b1;
        row.result = res;
        return row;
    endfunction

    function automatic t_row pattern_row(logic [LEN_BITS-1:0] len,
                                         logic [CFG_DATA_BITS-1:0] classes,
                                         logic [PAT_SLOTS-1:0] mand);
        t_row row;
        row = '0;
        row.kind = ROW_PATTERN;
        row.pat_len = len;
        row.pat_classes = classes;
        row.pat_mand = mand;
        return row;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(t_row row);
        plan = {plan, row};
    endfunction

    // Mostly well-formed words aimed at the current or a later slot, the rest noise.
    function automatic t_in_item pick_token();
        t_in_item req;
        int t;
        int r;
        logic [CODE_BITS-1:0] code;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            t = (phrase_mode == M_MATCH) ? int'(phrase_slot) : 0;
            if ($urandom_range(0, 3) == 0) t = t + $urandom_range(1, 3);
            if (t >= PAT_SLOTS) t = PAT_SLOTS - 1;
            code = pat_classes[CODE_BITS*t +: CODE_BITS];
            req.token_classes = ($urandom_range(0, 3) == 0) ? 6'($urandom) & 6'b011110 : '0;
            if (code <= CODE_BITS'(CLS_PUNCT)) req.token_classes[code] = 1'b1;
        end else if (r < 75) begin
            req.token_classes = 6'($urandom) & 6'b011110;
        end else if (r < 88) begin
            req.token_classes = 6'($urandom);
        end else begin
            req.token_classes = 6'($urandom) | 6'b000001;
        end
        r = $urandom_range(0, 9);
        req.token_column = (r == 0) ? '0 : (r == 1) ? '1 : 16'($urandom);
        r = $urandom_range(0, 9);
        req.line_number = (r == 0) ? '0 : (r == 1) ? '1 : 20'($urandom);
        return req;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_classes();
        logic [CFG_DATA_BITS-1:0] classes;
        int s;
        for (s = 0; s < PAT_SLOTS; s++) begin
            classes[CODE_BITS*s +: CODE_BITS] = ($urandom_range(0, 99) < 85) ?
                3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        end
        return classes;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        end
        mismatch_count++;
    endtask

    // Presents one request, holds it until accepted, and records its result.
    task automatic send_token(t_in_item req, logic typed, t_out_item typed_result);
        t_out_item res;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        res = predict_phrase_step(req);
        phrase_results_q = {phrase_results_q, (typed ? typed_result : res)};
    endtask

    // Bursts of back-to-back requests separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
        burst_left = $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and lets every outstanding result come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (phrase_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_LENGTH:    pat_len = value[LEN_BITS-1:0];
            CFG_CLASSES:   pat_classes = value;
            CFG_MANDATORY: pat_mand = value[PAT_SLOTS-1:0];
            default: ;
        endcase
    endtask

    // The matcher state is left as it is, so a phrase may span a new pattern.
    task automatic write_pattern(logic [LEN_BITS-1:0] len, logic [CFG_DATA_BITS-1:0] classes,
                                 logic [PAT_SLOTS-1:0] mand);
        wait_idle();
        write_reg(CFG_LENGTH, CFG_DATA_BITS'(len));
        write_reg(CFG_CLASSES, classes);
        write_reg(CFG_MANDATORY, CFG_DATA_BITS'(mand));
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver switches between free flow, random stalls, heavy stalls and hard stops.
    always @(posedge i_clk) begin : rx_pattern
        logic ready;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: rx_left = $urandom_range(5, 60);
                1: rx_left = $urandom_range(10, 80);
                2: rx_left = $urandom_range(10, 40);
                default: rx_left = $urandom_range(1, 8);
            endcase
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: ready = 1'b1;
            1: ready = 1'($urandom_range(0, 1));
            2: ready = ($urandom_range(0, 7) == 0);
            default: ready = 1'b0;
        endcase
        i_out_ready <= ready;
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (phrase_results_q.size() == 0) begin
                report_mismatch("result with none pending", 64'(o_out_data), '0);
            end else begin
                want = phrase_results_q.pop_front();
                if (o_out_data.token_action !== want.token_action)
                    report_mismatch("token_action", 64'(o_out_data.token_action),
                                    64'(want.token_action));
                if (o_out_data.phrase_started !== want.phrase_started)
                    report_mismatch("phrase_started", 64'(o_out_data.phrase_started),
                                    64'(want.phrase_started));
                if (o_out_data.phrase_found !== want.phrase_found)
                    report_mismatch("phrase_found", 64'(o_out_data.phrase_found),
                                    64'(want.phrase_found));
                if (o_out_data.start_column !== want.start_column)
                    report_mismatch("start_column", 64'(o_out_data.start_column),
                                    64'(want.start_column));
                if (o_out_data.found_line !== want.found_line)
                    report_mismatch("found_line", 64'(o_out_data.found_line),
                                    64'(want.found_line));
            end
        end
    end

    // Ends the run when no request, result or register write moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_in_item req;
        int phase;
        int words;
        logic [LEN_BITS-1:0] len;
        logic [PAT_SLOTS-1:0] mand;

        // Default pattern: one mandatory article slot, so nothing ever matches.
        add_row(checked_row(6'b000010, '0, '0, result_of(ACT_NOMATCH, 0, 0, '0, '0)));
        add_row(checked_row(6'b111111, '1, '1, result_of(ACT_ARTICLE, 0, 0, '0, '0)));
        add_row(checked_row(6'b100000, '1, '1, result_of(ACT_NOMATCH, 0, 0, '0, '0)));
        // Pronoun, optional verb, mandatory preposition.
        add_row(pattern_row(4'd3, 24'h000111, 8'h05));
        add_row(checked_row(6'b000010, 16'd10, 20'd1,
                            result_of(ACT_TAKE, 1, 0, 16'd10, '0)));
        add_row(word_row(6'b001000, 16'd20, 20'd1));
        add_row(word_row(6'b010100, 16'd30, 20'd1));
        add_row(checked_row(6'b010000, 16'd40, '1,
                            result_of(ACT_TAKE, 0, 1, 16'd10, '1)));
        // Jump over the optional verb straight to the preposition.
        add_row(word_row(6'b000010, '1, 20'd5));
        add_row(word_row(6'b010000, 16'd1, 20'd6));
        // An article inside a phrase, then punctuation abandons it.
        add_row(word_row(6'b000010, 16'd2, 20'd7));
        add_row(word_row(6'b000001, 16'd3, 20'd7));
        add_row(checked_row(6'b100100, 16'd4, 20'd7,
                            result_of(ACT_ABANDON, 0, 0, '0, '0)));
        add_row(word_row(6'b000100, 16'd5, 20'd8));
        add_row(word_row(6'b000000, '0, '0));
        add_row(word_row(6'b000010, 16'd7, 20'd9));
        add_row(word_row(6'b000010, 16'd8, 20'd9));
        // Shrinking the length mid-phrase leaves the slot past the end.
        add_row(pattern_row(4'd1, 24'h000111, 8'h05));
        add_row(word_row(6'b000100, 16'd9, 20'd77));
        // Zero length and class codes that no token can fit.
        add_row(pattern_row(4'd0, 24'hFFFFFF, 8'h00));
        add_row(word_row(6'b000100, 16'd11, 20'd78));
        add_row(word_row(6'b011110, 16'd12, 20'd79));
        // Length above the slot count, every slot punctuation.
        add_row(pattern_row(4'd15, 24'hB6DB6D, 8'hFF));
        add_row(word_row(6'b100000, 16'd13, 20'd80));
        add_row(word_row(6'b011110, 16'd14, 20'd81));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_PATTERN) begin
                write_pattern(plan[i].pat_len, plan[i].pat_classes, plan[i].pat_mand);
            end else begin
                send_token(plan[i].req, plan[i].typed, plan[i].result);
                pace_sender();
            end
        end

        // Random phases, each under a new pattern written while the block is idle.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin len = 4'd8; mand = 8'hFF; end
                1: begin len = 4'd1; mand = 8'h00; end
                2: begin len = 4'd8; mand = 8'h00; end
                default: begin
                    len = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    mand = 8'($urandom);
                end
            endcase
            write_pattern(len, random_classes(), mand);
            words = 0;
            while (words < WORDS_PER_PHASE) begin
                req = pick_token();
                words++;
                send_token(req, 1'b0, '0);
                pace_sender();
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
